[design/spl_pkg.sv]
`default_nettype none
package spl_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned TAG_W        = 16;
  localparam int unsigned CNT_OUT_W    = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [KEY_W-1:0] key;
  } slot_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic  ins;
    logic  pop;
    logic  descending;
    slot_t item;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[design/spl_cell.sv]
`default_nettype none
module spl_cell #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX   = 0
) (
  input  wire logic              clk,
  input  wire spl_pkg::cell_ctrl_t ctrl,
  input  wire logic [CNT_W-1:0]  count,
  input  wire spl_pkg::slot_t    left_data,
  input  wire logic              left_before,
  input  wire logic              left_occ,
  input  wire spl_pkg::slot_t    right_data,
  output spl_pkg::slot_t         data,
  output logic                   ahead,
  output logic                   occ
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  spl_pkg::slot_t data_next;
  logic           precede_here;

  assign occ          = (count > IDX_C);
  assign precede_here = occ && (ctrl.descending ? (ctrl.item.key > data.key)
                                                : (ctrl.item.key < data.key));
  // insertion point lies at or left of this cell; the stored order may not
  // match the current compare after an order change, so this is a running OR
  assign ahead = left_before || precede_here;

  always_comb begin
    data_next = data;
    if (ctrl.ins) begin
      if (left_before) begin
        data_next = left_data;          // shift right to make room
      end else if (precede_here || (!occ && left_occ)) begin
        data_next = ctrl.item;          // insertion point
      end
    end else if (ctrl.pop) begin
      data_next = right_data;           // shift toward head
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
`default_nettype wire

[design/sorted_insert_priority_list_core.sv]
`default_nettype none
// A result word appears on m_tvalid in the cycle after its command is accepted.
// Throughput: one command per cycle while results are taken; a held result stalls
//   intake, as the output register holds only one result.
// Each insert or pop is one parallel compare-and-shift step across the cell chain.
// Reset (rst, synchronous, active high) empties the list, clears the output valid
//   and sets ascending order; slot contents are not cleared.
module sorted_insert_priority_list_core #(
  parameter int unsigned CAPACITY = spl_pkg::CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: order_descending
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  // command stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // [31:0] item_key, [47:32] item_tag
  input  wire logic [1:0]  s_tuser,   // [1:0] cmd
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [31:0] head_key, [47:32] head_tag,
                                      // [52:48] item_count, [55:53] zero
  output logic [1:0]       m_tuser    // [1:0] status
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  // order register
  logic descending;
  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (cfg_wr_en) begin
      descending <= cfg_wr_data;
    end
  end

  // fill count
  logic [CNT_W-1:0] count, count_next;

  logic accept;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  spl_pkg::cmd_t cmd;
  assign cmd = spl_pkg::cmd_t'(s_tuser);

  logic is_empty, is_full;
  assign is_empty = (count == '0);
  assign is_full  = (count == CAP_C);

  spl_pkg::cell_ctrl_t ctrl;
  assign ctrl.ins        = accept && (cmd == spl_pkg::CMD_INSERT) && !is_full;
  assign ctrl.pop        = accept && (cmd == spl_pkg::CMD_POP) && !is_empty;
  assign ctrl.descending = descending;
  assign ctrl.item       = spl_pkg::slot_t'(s_tdata);

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // cell chain; cell 0 is the head
  // cell_before: the insertion point is at or left of that cell
  spl_pkg::slot_t cell_data   [CAPACITY];
  logic           cell_before [CAPACITY];
  logic           cell_occ    [CAPACITY];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      spl_pkg::slot_t l_data, r_data;
      logic           l_before, l_occ;
      if (gi == 0) begin : g_head
        // head: nothing to its left, empty list appends here
        assign l_data   = '0;
        assign l_before = 1'b0;
        assign l_occ    = 1'b1;
      end else begin : g_mid
        assign l_data   = cell_data[gi-1];
        assign l_before = cell_before[gi-1];
        assign l_occ    = cell_occ[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
        assign r_data = '0;
      end else begin : g_nxt
        assign r_data = cell_data[gi+1];
      end

      spl_cell #(
        .CNT_W (CNT_W),
        .IDX   (gi)
      ) u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .count       (count),
        .left_data   (l_data),
        .left_before (l_before),
        .left_occ    (l_occ),
        .right_data  (r_data),
        .data        (cell_data[gi]),
        .ahead       (cell_before[gi]),
        .occ         (cell_occ[gi])
      );
    end
  endgenerate

  // result word built from pre-update head and post-update count
  spl_pkg::status_t res_status;
  spl_pkg::slot_t   res_head;
  logic [CNT_W+spl_pkg::CNT_OUT_W-1:0] cnt_ext;

  always_comb begin
    res_status = spl_pkg::ST_DONE;
    res_head   = '0;
    case (cmd)
      spl_pkg::CMD_INSERT: begin
        if (is_full) begin
          res_status = spl_pkg::ST_FULL;
        end
      end
      spl_pkg::CMD_POP, spl_pkg::CMD_PEEK: begin
        if (is_empty) begin
          res_status = spl_pkg::ST_EMPTY;
        end else begin
          res_head = cell_data[0];
        end
      end
      default: begin
        res_status = spl_pkg::ST_DONE;
      end
    endcase
  end

  assign cnt_ext = {{spl_pkg::CNT_OUT_W{1'b0}}, count_next};

  // output register
  spl_pkg::status_t                  out_status;
  spl_pkg::slot_t                    out_head;
  logic [spl_pkg::CNT_OUT_W-1:0]     out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= res_status;
      out_head   <= res_head;
      out_count  <= cnt_ext[spl_pkg::CNT_OUT_W-1:0];
    end
  end

  assign m_tdata = {3'b000, out_count, out_head.tag, out_head.key};
  assign m_tuser = out_status;

endmodule
`default_nettype wire
